// File: sv/psc_pkg.sv
// Shared types, codes and constants for the speed-loop PID controller.
// Used by psc_iter_unit and pid_speed_controller_antiwindup_core; depends on nothing.

package psc_pkg;

    // Default widths of the fixed-point data path.
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int INTEG_WIDTH_DEF = 48;

    // The raw controller sum always saturates to a signed 64-bit range.
    localparam int RAW_WIDTH = 64;

    // Digit width of the iterative multiplier.
    localparam int DIGIT_WIDTH = 8;

    // Integer part of the default drive limits (plus and minus this value).
    localparam int DRIVE_LIMIT_INT = 255;

    // Configuration register indexes.
    localparam int CFG_ADDR_WIDTH = 3;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_DRIVE_FLOOR   = 3'd3,
        REG_DRIVE_CEILING = 3'd4
    } psc_cfg_reg_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic {
        PSC_OP_MUL,
        PSC_OP_DIV
    } psc_op_t;

    // Which product the sequencer is forming.
    typedef enum logic [1:0] {
        PSC_P_KP,
        PSC_P_KI,
        PSC_P_KD,
        PSC_P_INC
    } psc_prod_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        PSC_S_IDLE,
        PSC_S_ERROR,
        PSC_S_DIV_START,
        PSC_S_DIV_RUN,
        PSC_S_MUL_START,
        PSC_S_MUL_RUN,
        PSC_S_ACCUM,
        PSC_S_FINISH,
        PSC_S_DONE
    } psc_state_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic    start;
        psc_op_t op;
    } psc_unit_ctl_t;

    // Status from the arithmetic unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } psc_unit_stat_t;

endpackage

// File: sv/psc_iter_unit.sv
// Shared iterative arithmetic unit: unsigned digit-serial multiply and
// restoring divide of (opa << FRAC_BITS) by opb. Depends on psc_pkg.

module psc_iter_unit #(
    parameter int DATA_WIDTH = psc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = psc_pkg::FRAC_BITS_DEF,
    parameter int OPB_WIDTH  = psc_pkg::INTEG_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  psc_pkg::psc_unit_ctl_t          ctl,
    input  logic [DATA_WIDTH-1:0]           opa,
    input  logic [OPB_WIDTH-1:0]            opb,
    output psc_pkg::psc_unit_stat_t         stat,
    output logic [DATA_WIDTH+OPB_WIDTH-1:0] result
);

    localparam int DGW  = psc_pkg::DIGIT_WIDTH;
    localparam int ND   = (DATA_WIDTH + DGW - 1) / DGW;
    localparam int AW   = ND * DGW;
    localparam int PW   = DATA_WIDTH + OPB_WIDTH;
    localparam int QW   = DATA_WIDTH + FRAC_BITS;
    localparam int CNTW = $clog2(QW + 1);

    logic [PW-1:0]         acc_reg, acc_next;
    logic [AW-1:0]         a_reg, a_next;
    logic [OPB_WIDTH-1:0]  b_reg, b_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;
    psc_pkg::psc_op_t      op_reg, op_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DGW-1:0]           digit;
    logic [OPB_WIDTH+DGW-1:0] pp;
    logic [DATA_WIDTH:0]      trial;
    logic [DATA_WIDTH:0]      divisor;
    logic [DATA_WIDTH:0]      rem_sub;
    logic                     ge;

    // One multiplier digit per cycle, most significant digit first.
    assign digit = a_reg[AW-1 -: DGW];
    assign pp    = b_reg * digit;

    // One quotient bit per cycle.
    assign trial   = {rem_reg, acc_reg[QW-1]};
    assign divisor = {1'b0, b_reg[DATA_WIDTH-1:0]};
    assign ge      = (trial >= divisor);
    assign rem_sub = trial - divisor;

    // Next-state logic for both operations.
    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            busy_next = 1'b1;
            rem_next  = '0;
            op_next   = ctl.op;
            b_next    = opb;
            case (ctl.op)
                psc_pkg::PSC_OP_MUL: begin
                    acc_next = '0;
                    a_next   = AW'(opa);
                    cnt_next = CNTW'(ND);
                end
                psc_pkg::PSC_OP_DIV: begin
                    acc_next = PW'({opa, FRAC_BITS'(0)});
                    a_next   = '0;
                    cnt_next = CNTW'(QW);
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                psc_pkg::PSC_OP_MUL: begin
                    acc_next = (acc_reg << DGW) + PW'(pp);
                    a_next   = a_reg << DGW;
                end
                psc_pkg::PSC_OP_DIV: begin
                    acc_next = PW'({acc_reg[QW-2:0], ge});
                    rem_next = ge ? rem_sub[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; operands and partial results are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= psc_pkg::PSC_OP_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

// File: sv/pid_speed_controller_antiwindup_core.sv
// Top level of the speed-loop PID controller with clamping anti-windup.
// Depends on psc_pkg and psc_iter_unit.
//
//   Channel   Direction  Handshake          Contents
//   s_        in         s_tvalid/s_tready  target_speed, measured_speed, time_step
//   m_        out        m_tvalid/m_tready  drive_value; flags was_clamped, step_rejected
//   cfg_      in         cfg_wr_en          gains and drive limits, no read-back
//
// One beat runs the bit-serial divide and up to four digit-serial products, all
// through the single arithmetic unit; the divide is skipped while there is no
// error history, and the integral product is skipped when anti-windup holds.
// A beat with time_step zero or negative is rejected without using the unit.
// Reset is synchronous and active low; it clears the integral and the history.
// s_tready is high only in the idle state; a finished result waits in the
// output register while the next beat is already being worked on.

module pid_speed_controller_antiwindup_core #(
    parameter int DATA_WIDTH  = psc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = psc_pkg::FRAC_BITS_DEF,
    parameter int INTEG_WIDTH = psc_pkg::INTEG_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Fields from bit 0: target_speed, measured_speed, time_step.
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // Fields from bit 0: drive_value.
    output logic [((DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
    // Fields from bit 0: was_clamped, step_rejected.
    output logic [1:0]                              m_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_wr_en,
    input  logic [psc_pkg::CFG_ADDR_WIDTH-1:0]      cfg_addr,
    input  logic [DATA_WIDTH-1:0]                   cfg_wdata
);

    localparam int DW    = DATA_WIDTH;
    localparam int IW    = INTEG_WIDTH;
    localparam int RW    = psc_pkg::RAW_WIDTH;
    localparam int BW    = (IW > DW) ? IW : DW;
    localparam int PW    = DW + BW;
    localparam int QW    = DW + FRAC_BITS;
    localparam int EW    = ((PW > RW) ? PW : RW) + 1;
    localparam int OUT_W = ((DW + 7) / 8) * 8;

    // Reset values of the drive limits, saturated to the data width.
    localparam logic [RW-1:0] LIMIT_MAG = RW'(psc_pkg::DRIVE_LIMIT_INT) << FRAC_BITS;
    localparam logic [RW-1:0] DATA_MAX  = (RW'(1) << (DW - 1)) - RW'(1);
    localparam logic [RW-1:0] CEIL_MAG  = (LIMIT_MAG > DATA_MAX) ? DATA_MAX : LIMIT_MAG;
    localparam logic [RW-1:0] FLOOR_MAG =
        (LIMIT_MAG > DATA_MAX + RW'(1)) ? DATA_MAX + RW'(1) : LIMIT_MAG;
    localparam logic [RW-1:0] FLOOR_FULL = RW'(0) - FLOOR_MAG;
    localparam logic [DW-1:0] CEIL_RST   = CEIL_MAG[DW-1:0];
    localparam logic [DW-1:0] FLOOR_RST  = FLOOR_FULL[DW-1:0];

    // Configuration registers.
    logic [DW-1:0] kp_reg, ki_reg, kd_reg, floor_reg, ceil_reg;

    // Sequencer and data path registers.
    psc_pkg::psc_state_t state_reg, state_next;
    psc_pkg::psc_prod_t  prod_reg, prod_next;
    logic [DW-1:0] tgt_reg, tgt_next;
    logic [DW-1:0] meas_reg, meas_next;
    logic [DW-1:0] dt_reg, dt_next;
    logic [DW-1:0] err_reg, err_next;
    logic [DW-1:0] deriv_reg, deriv_next;
    logic [DW-1:0] last_err_reg, last_err_next;
    logic          hist_reg, hist_next;
    logic          diff_neg_reg, diff_neg_next;
    logic          prod_neg_reg, prod_neg_next;
    logic [RW-1:0] raw_reg, raw_next;
    logic [IW-1:0] integ_reg, integ_next;
    logic [DW-1:0] drive_reg, drive_next;
    logic          clamp_reg, clamp_next;
    logic          rej_reg, rej_next;
    logic [DW-1:0] out_drive_reg, out_drive_next;
    logic          out_clamp_reg, out_clamp_next;
    logic          out_rej_reg, out_rej_next;
    logic          m_valid_reg, m_valid_next;

    // Arithmetic unit connections.
    psc_pkg::psc_unit_ctl_t  unit_ctl;
    psc_pkg::psc_unit_stat_t unit_stat;
    logic [DW-1:0]           unit_a;
    logic [BW-1:0]           unit_b;
    logic [PW-1:0]           unit_result;

    psc_iter_unit #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS),
        .OPB_WIDTH  (BW)
    ) u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (unit_ctl),
        .opa     (unit_a),
        .opb     (unit_b),
        .stat    (unit_stat),
        .result  (unit_result)
    );

    // Error, saturated to the data width.
    logic [DW:0]   err_wide;
    logic [DW-1:0] err_sat;
    logic          dt_bad;
    assign err_wide = {tgt_reg[DW-1], tgt_reg} - {meas_reg[DW-1], meas_reg};
    assign err_sat  = (err_wide[DW] != err_wide[DW-1])
                    ? {err_wide[DW], {(DW-1){~err_wide[DW]}}} : err_wide[DW-1:0];
    assign dt_bad   = dt_reg[DW-1] || (dt_reg == '0);

    // Change in error and its magnitude for the divide.
    logic [DW:0] diff_wide;
    logic [DW:0] diff_abs;
    assign diff_wide = {err_reg[DW-1], err_reg} - {last_err_reg[DW-1], last_err_reg};
    assign diff_abs  = diff_wide[DW] ? ((DW+1)'(0) - diff_wide) : diff_wide;

    // Derivative: quotient magnitude saturated to the data width.
    logic [QW-1:0] quot;
    logic [QW-1:0] quot_lim;
    logic [QW-1:0] quot_neg;
    logic [DW-1:0] deriv_sat;
    assign quot     = unit_result[QW-1:0];
    assign quot_lim = {{(FRAC_BITS+1){1'b0}}, {(DW-1){1'b1}}};
    assign quot_neg = QW'(0) - quot;
    always_comb begin
        if (!diff_neg_reg) begin
            deriv_sat = (quot > quot_lim) ? {1'b0, {(DW-1){1'b1}}} : quot[DW-1:0];
        end else begin
            deriv_sat = (quot > quot_lim + QW'(1)) ? {1'b1, {(DW-1){1'b0}}}
                                                   : quot_neg[DW-1:0];
        end
    end

    // Product magnitude after the fraction shift, then signed saturation.
    logic [EW-1:0] prod_mag;
    logic [EW-1:0] prod_mag_neg;
    logic [EW-1:0] raw_lim;
    logic [EW-1:0] integ_lim;
    logic [RW-1:0] prod_raw;
    logic [IW-1:0] prod_inc;
    assign prod_mag     = {{(EW-PW){1'b0}}, unit_result >> FRAC_BITS};
    assign prod_mag_neg = EW'(0) - prod_mag;
    assign raw_lim      = {{(EW-RW+1){1'b0}}, {(RW-1){1'b1}}};
    assign integ_lim    = {{(EW-IW+1){1'b0}}, {(IW-1){1'b1}}};
    always_comb begin
        if (!prod_neg_reg) begin
            prod_raw = (prod_mag > raw_lim) ? {1'b0, {(RW-1){1'b1}}} : prod_mag[RW-1:0];
            prod_inc = (prod_mag > integ_lim) ? {1'b0, {(IW-1){1'b1}}} : prod_mag[IW-1:0];
        end else begin
            prod_raw = (prod_mag > raw_lim + EW'(1)) ? {1'b1, {(RW-1){1'b0}}}
                                                     : prod_mag_neg[RW-1:0];
            prod_inc = (prod_mag > integ_lim + EW'(1)) ? {1'b1, {(IW-1){1'b0}}}
                                                       : prod_mag_neg[IW-1:0];
        end
    end

    // Saturating accumulate of the raw output.
    logic [RW:0]   raw_sum;
    logic [RW-1:0] raw_sat;
    assign raw_sum = {raw_reg[RW-1], raw_reg} + {prod_raw[RW-1], prod_raw};
    assign raw_sat = (raw_sum[RW] != raw_sum[RW-1])
                   ? {raw_sum[RW], {(RW-1){~raw_sum[RW]}}} : raw_sum[RW-1:0];

    // Saturating integral update.
    logic [IW:0]   integ_sum;
    logic [IW-1:0] integ_sat;
    assign integ_sum = {integ_reg[IW-1], integ_reg} + {prod_inc[IW-1], prod_inc};
    assign integ_sat = (integ_sum[IW] != integ_sum[IW-1])
                     ? {integ_sum[IW], {(IW-1){~integ_sum[IW]}}} : integ_sum[IW-1:0];

    // Limit compares on the raw output; the floor wins over the ceiling.
    logic [RW-1:0] ceil_ext, floor_ext;
    logic          above_ceil, below_floor, ceil_below_floor;
    logic [DW-1:0] drive_clamped;
    logic          hold_now;
    assign ceil_ext         = {{(RW-DW){ceil_reg[DW-1]}}, ceil_reg};
    assign floor_ext        = {{(RW-DW){floor_reg[DW-1]}}, floor_reg};
    assign above_ceil       = ($signed(raw_reg) > $signed(ceil_ext));
    assign below_floor      = ($signed(raw_reg) < $signed(floor_ext));
    assign ceil_below_floor = ($signed(ceil_reg) < $signed(floor_reg));
    assign drive_clamped    = above_ceil ? (ceil_below_floor ? floor_reg : ceil_reg)
                                         : (below_floor ? floor_reg : raw_reg[DW-1:0]);
    assign hold_now = (above_ceil && !err_reg[DW-1] && (err_reg != '0))
                   || (below_floor && err_reg[DW-1]);

    // Operand selection for the four products.
    logic [DW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [DW-1:0] mul_a_abs;
    logic [BW-1:0] mul_b_abs;
    always_comb begin
        case (prod_reg)
            psc_pkg::PSC_P_KP: begin
                mul_a = kp_reg;
                mul_b = {{(BW-DW){err_reg[DW-1]}}, err_reg};
            end
            psc_pkg::PSC_P_KI: begin
                mul_a = ki_reg;
                mul_b = {{(BW-IW){integ_reg[IW-1]}}, integ_reg};
            end
            psc_pkg::PSC_P_KD: begin
                mul_a = kd_reg;
                mul_b = {{(BW-DW){deriv_reg[DW-1]}}, deriv_reg};
            end
            psc_pkg::PSC_P_INC: begin
                mul_a = err_reg;
                mul_b = {{(BW-DW){dt_reg[DW-1]}}, dt_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_a_abs = mul_a[DW-1] ? (DW'(0) - mul_a) : mul_a;
    assign mul_b_abs = mul_b[BW-1] ? (BW'(0) - mul_b) : mul_b;

    // Sequencer: next state and data path updates.
    always_comb begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        tgt_next       = tgt_reg;
        meas_next      = meas_reg;
        dt_next        = dt_reg;
        err_next       = err_reg;
        deriv_next     = deriv_reg;
        last_err_next  = last_err_reg;
        hist_next      = hist_reg;
        diff_neg_next  = diff_neg_reg;
        prod_neg_next  = prod_neg_reg;
        raw_next       = raw_reg;
        integ_next     = integ_reg;
        drive_next     = drive_reg;
        clamp_next     = clamp_reg;
        rej_next       = rej_reg;
        out_drive_next = out_drive_reg;
        out_clamp_next = out_clamp_reg;
        out_rej_next   = out_rej_reg;
        m_valid_next   = m_valid_reg;
        unit_ctl.start = 1'b0;
        unit_ctl.op    = psc_pkg::PSC_OP_MUL;
        unit_a         = '0;
        unit_b         = '0;

        // The output beat leaves when the sink takes it.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            psc_pkg::PSC_S_IDLE: begin
                if (s_tvalid) begin
                    tgt_next   = s_tdata[DW-1:0];
                    meas_next  = s_tdata[2*DW-1:DW];
                    dt_next    = s_tdata[3*DW-1:2*DW];
                    state_next = psc_pkg::PSC_S_ERROR;
                end
            end
            psc_pkg::PSC_S_ERROR: begin
                if (dt_bad) begin
                    drive_next = '0;
                    clamp_next = 1'b0;
                    rej_next   = 1'b1;
                    state_next = psc_pkg::PSC_S_DONE;
                end else begin
                    err_next   = err_sat;
                    deriv_next = '0;
                    raw_next   = '0;
                    rej_next   = 1'b0;
                    prod_next  = psc_pkg::PSC_P_KP;
                    state_next = hist_reg ? psc_pkg::PSC_S_DIV_START
                                          : psc_pkg::PSC_S_MUL_START;
                end
            end
            psc_pkg::PSC_S_DIV_START: begin
                unit_ctl.start = 1'b1;
                unit_ctl.op    = psc_pkg::PSC_OP_DIV;
                unit_a         = diff_abs[DW-1:0];
                unit_b         = BW'(dt_reg);
                diff_neg_next  = diff_wide[DW];
                state_next     = psc_pkg::PSC_S_DIV_RUN;
            end
            psc_pkg::PSC_S_DIV_RUN: begin
                if (unit_stat.done) begin
                    deriv_next = deriv_sat;
                    state_next = psc_pkg::PSC_S_MUL_START;
                end
            end
            psc_pkg::PSC_S_MUL_START: begin
                unit_ctl.start = 1'b1;
                unit_ctl.op    = psc_pkg::PSC_OP_MUL;
                unit_a         = mul_a_abs;
                unit_b         = mul_b_abs;
                prod_neg_next  = mul_a[DW-1] ^ mul_b[BW-1];
                state_next     = psc_pkg::PSC_S_MUL_RUN;
            end
            psc_pkg::PSC_S_MUL_RUN: begin
                if (unit_stat.done) begin
                    state_next = psc_pkg::PSC_S_ACCUM;
                end
            end
            psc_pkg::PSC_S_ACCUM: begin
                case (prod_reg)
                    psc_pkg::PSC_P_KP: begin
                        raw_next   = raw_sat;
                        prod_next  = psc_pkg::PSC_P_KI;
                        state_next = psc_pkg::PSC_S_MUL_START;
                    end
                    psc_pkg::PSC_P_KI: begin
                        raw_next   = raw_sat;
                        prod_next  = psc_pkg::PSC_P_KD;
                        state_next = psc_pkg::PSC_S_MUL_START;
                    end
                    psc_pkg::PSC_P_KD: begin
                        raw_next   = raw_sat;
                        state_next = psc_pkg::PSC_S_FINISH;
                    end
                    psc_pkg::PSC_P_INC: begin
                        integ_next = integ_sat;
                        state_next = psc_pkg::PSC_S_DONE;
                    end
                    default: begin
                        state_next = psc_pkg::PSC_S_DONE;
                    end
                endcase
            end
            psc_pkg::PSC_S_FINISH: begin
                drive_next    = drive_clamped;
                clamp_next    = above_ceil || below_floor;
                last_err_next = err_reg;
                hist_next     = 1'b1;
                // Anti-windup: skip the integral when pushing into a limit.
                if (hold_now) begin
                    state_next = psc_pkg::PSC_S_DONE;
                end else begin
                    prod_next  = psc_pkg::PSC_P_INC;
                    state_next = psc_pkg::PSC_S_MUL_START;
                end
            end
            psc_pkg::PSC_S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_drive_next = drive_reg;
                    out_clamp_next = clamp_reg;
                    out_rej_next   = rej_reg;
                    m_valid_next   = 1'b1;
                    state_next     = psc_pkg::PSC_S_IDLE;
                end
            end
            default: begin
                state_next = psc_pkg::PSC_S_IDLE;
            end
        endcase
    end

    // Sequencer, controller state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= psc_pkg::PSC_S_IDLE;
            prod_reg     <= psc_pkg::PSC_P_KP;
            integ_reg    <= '0;
            last_err_reg <= '0;
            hist_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            prod_reg     <= prod_next;
            integ_reg    <= integ_next;
            last_err_reg <= last_err_next;
            hist_reg     <= hist_next;
            m_valid_reg  <= m_valid_next;
        end
        tgt_reg       <= tgt_next;
        meas_reg      <= meas_next;
        dt_reg        <= dt_next;
        err_reg       <= err_next;
        deriv_reg     <= deriv_next;
        diff_neg_reg  <= diff_neg_next;
        prod_neg_reg  <= prod_neg_next;
        raw_reg       <= raw_next;
        drive_reg     <= drive_next;
        clamp_reg     <= clamp_next;
        rej_reg       <= rej_next;
        out_drive_reg <= out_drive_next;
        out_clamp_reg <= out_clamp_next;
        out_rej_reg   <= out_rej_next;
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            floor_reg <= FLOOR_RST;
            ceil_reg  <= CEIL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                psc_pkg::REG_PROP_GAIN:     kp_reg    <= cfg_wdata;
                psc_pkg::REG_INTEG_GAIN:    ki_reg    <= cfg_wdata;
                psc_pkg::REG_DERIV_GAIN:    kd_reg    <= cfg_wdata;
                psc_pkg::REG_DRIVE_FLOOR:   floor_reg <= cfg_wdata;
                psc_pkg::REG_DRIVE_CEILING: ceil_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Channel outputs.
    assign s_tready = (state_reg == psc_pkg::PSC_S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(out_drive_reg);
    assign m_tuser  = {out_rej_reg, out_clamp_reg};

    // The arithmetic unit is never left running while the sequencer is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == psc_pkg::PSC_S_IDLE) |-> !unit_stat.busy)
        else $error("arithmetic unit busy while sequencer idle");

    // A rejected beat carries a zero drive and no clamp flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> ((m_tdata == '0) && !m_tuser[0]))
        else $error("rejected beat with nonzero drive or clamp flag");

    // A rejected time step leaves the integral and history untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == psc_pkg::PSC_S_ERROR) && dt_bad)
        |=> ($stable(integ_reg) && $stable(hist_reg) && $stable(last_err_reg)))
        else $error("controller state changed on rejected step");

endmodule
